>>> hdl/sceq_pkg.sv
package sceq_pkg;

  localparam int KIND_W    = 8;
  localparam int TIME_W    = 32;
  localparam int DELAY_W   = 31;
  localparam int FRAME_W   = 20;
  localparam int OCC_W     = 5;
  localparam int CFG_IDX_W = 8;

  typedef enum logic [1:0] {
    FUNC_ADD       = 2'd0,
    FUNC_TICK      = 2'd1,
    FUNC_CLR_RANGE = 2'd2,
    FUNC_CLR_ALL   = 2'd3
  } func_t;

  typedef logic [KIND_W-1:0]        kind_t;
  typedef logic signed [TIME_W-1:0] qtime_t;
  typedef logic [DELAY_W-1:0]       delay_t;
  typedef logic [FRAME_W-1:0]       frame_t;
  typedef logic [OCC_W-1:0]         occ_t;
  typedef logic [CFG_IDX_W-1:0]     cfg_idx_t;

  localparam cfg_idx_t REG_FIRST_KIND = cfg_idx_t'(0);
  localparam cfg_idx_t REG_LAST_KIND  = cfg_idx_t'(1);

  localparam qtime_t TIME_MIN = qtime_t'(32'h8000_0000);

  // Per-cycle command broadcast to every cell of the chain.
  typedef struct packed {
    logic add;    // insert the new entry at its sorted place
    logic tick;   // count every entry down by the frame time
    logic pop;    // with tick: the head expired, shift everything left
    logic shift;  // remove the first entry in the kind range
  } cell_ctl_t;

endpackage

>>> hdl/sceq_in_if.sv
interface sceq_in_if;
  logic             valid;
  logic             ready;
  sceq_pkg::func_t  func;
  sceq_pkg::kind_t  event_kind;
  sceq_pkg::delay_t delay;
  sceq_pkg::frame_t frame_time;

  modport source (output valid, func, event_kind, delay, frame_time, input ready);
  modport sink (input valid, func, event_kind, delay, frame_time, output ready);
endinterface

>>> hdl/sceq_out_if.sv
interface sceq_out_if;
  logic            valid;
  logic            ready;
  logic            fired;
  sceq_pkg::kind_t fired_kind;
  logic            dropped;
  sceq_pkg::occ_t  occupancy;

  modport source (output valid, fired, fired_kind, dropped, occupancy, input ready);
  modport sink (input valid, fired, fired_kind, dropped, occupancy, output ready);
endinterface

>>> hdl/sceq_cfg_if.sv
interface sceq_cfg_if;
  logic               valid;
  logic               ready;
  sceq_pkg::cfg_idx_t index;
  sceq_pkg::kind_t    data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

>>> hdl/sceq_cell.sv
module sceq_cell (
  input  logic                clk,
  input  sceq_pkg::cell_ctl_t ctl,
  input  logic                valid,
  input  sceq_pkg::kind_t     new_kind,
  input  sceq_pkg::qtime_t    new_time,
  input  sceq_pkg::frame_t    frame_time,
  input  sceq_pkg::kind_t     first_kind,
  input  sceq_pkg::kind_t     last_kind,
  input  sceq_pkg::kind_t     left_kind,
  input  sceq_pkg::qtime_t    left_time,
  input  logic                left_ins,
  input  logic                hit_in,
  input  sceq_pkg::kind_t     right_kind,
  input  sceq_pkg::qtime_t    right_time,
  input  sceq_pkg::qtime_t    right_dec,
  output sceq_pkg::kind_t     cell_kind,
  output sceq_pkg::qtime_t    cell_time,
  output sceq_pkg::qtime_t    dec_time,
  output logic                ins,
  output logic                hit_out
);
  import sceq_pkg::*;

  kind_t               kind_r, kind_nxt;
  qtime_t              time_r, time_nxt;
  logic [TIME_W:0]     diff;
  logic                match;

  always_comb begin
    // Sign-extended subtract; overflow past the negative limit saturates.
    diff     = {time_r[TIME_W-1], time_r} - {{(TIME_W+1-FRAME_W){1'b0}}, frame_time};
    dec_time = (diff[TIME_W] & ~diff[TIME_W-1]) ? TIME_MIN : qtime_t'(diff[TIME_W-1:0]);
    // The insertion point is the first empty cell or the first later time.
    ins      = ~valid | (time_r > new_time);
    match    = valid & (kind_r >= first_kind) & (kind_r <= last_kind);
    hit_out  = hit_in | match;
  end

  always_comb begin
    kind_nxt = kind_r;
    time_nxt = time_r;
    if (ctl.add && ins) begin
      if (left_ins) begin
        kind_nxt = left_kind;
        time_nxt = left_time;
      end else begin
        kind_nxt = new_kind;
        time_nxt = new_time;
      end
    end else if (ctl.tick) begin
      if (ctl.pop) begin
        kind_nxt = right_kind;
        time_nxt = right_dec;
      end else begin
        time_nxt = dec_time;
      end
    end else if (ctl.shift && hit_out) begin
      kind_nxt = right_kind;
      time_nxt = right_time;
    end
  end

  always_ff @(posedge clk) begin
    kind_r <= kind_nxt;
    time_r <= time_nxt;
  end

  assign cell_kind = kind_r;
  assign cell_time = time_r;

endmodule

>>> hdl/sorted_countdown_event_queue.sv
// Sorted countdown event queue: a chain of QUEUE_DEPTH cells, each holding
// one event kind and its remaining Q16.16 time, kept in ascending order.
// Items enter on in_ch (func selects add, tick, clear kind range or clear
// all) and every item gives exactly one result item on out_ch carrying
// fired, fired_kind, dropped and the occupancy after the operation.
// cfg_ch writes the kind range used by clear-range; it is always ready.
// Add, tick and clear-all finish in the accept cycle and their result is
// registered, so it appears in the cycle after the accept; these items can be
// taken one per cycle while out_ch keeps up.
// Clear-range removes one matching entry per cycle by shifting the cells
// behind it left; while it runs, in_ch is not ready.
// A single output register holds the result; while the receiver stalls,
// in_ch is held off only once that register is full and not being taken.
// Reset (rst_n low at a clock edge) empties the queue, clears the output
// register's valid flag and sets both range registers to zero.
module sorted_countdown_event_queue #(
  parameter int QUEUE_DEPTH = 16
) (
  input logic    clk,
  input logic    rst_n,
  sceq_in_if.sink     in_ch,
  sceq_out_if.source  out_ch,
  sceq_cfg_if.sink    cfg_ch
);
  import sceq_pkg::*;

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic {ST_IDLE, ST_CLR} state_t;

  state_t          state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic            fired_r, fired_nxt;
  kind_t           fired_kind_r, fired_kind_nxt;
  logic            dropped_r, dropped_nxt;
  kind_t           first_kind_r, last_kind_r;

  logic            in_fire, out_free, full, any_hit;
  cell_ctl_t       ctl;
  qtime_t          new_time;

  kind_t           kind_q [QUEUE_DEPTH];
  qtime_t          time_q [QUEUE_DEPTH];
  qtime_t          dec_q  [QUEUE_DEPTH];
  logic            ins_q  [QUEUE_DEPTH];
  logic            hit_q  [QUEUE_DEPTH];

  assign in_fire  = in_ch.valid & in_ch.ready;
  assign out_free = ~out_valid_r | out_ch.ready;
  assign full     = (count_r == CNT_W'(QUEUE_DEPTH));
  assign any_hit  = hit_q[QUEUE_DEPTH-1];
  assign new_time = qtime_t'({1'b0, in_ch.delay});

  assign in_ch.ready = (state_r == ST_IDLE) & out_free;

  always_comb begin
    ctl.add   = in_fire & (in_ch.func == FUNC_ADD) & ~full;
    ctl.tick  = in_fire & (in_ch.func == FUNC_TICK) & (count_r != '0);
    ctl.pop   = ctl.tick & dec_q[0][TIME_W-1];
    ctl.shift = (state_r == ST_CLR) & any_hit;
  end

  genvar gi;
  generate
    for (gi = 0; gi < QUEUE_DEPTH; gi++) begin : g_cell
      kind_t  l_kind, r_kind;
      qtime_t l_time, r_time, r_dec;
      logic   l_ins, l_hit;
      if (gi == 0) begin : g_head
        assign l_kind = '0;
        assign l_time = '0;
        assign l_ins  = 1'b0;
        assign l_hit  = 1'b0;
      end else begin : g_body
        assign l_kind = kind_q[gi-1];
        assign l_time = time_q[gi-1];
        assign l_ins  = ins_q[gi-1];
        assign l_hit  = hit_q[gi-1];
      end
      if (gi == QUEUE_DEPTH - 1) begin : g_tail
        assign r_kind = '0;
        assign r_time = '0;
        assign r_dec  = '0;
      end else begin : g_inner
        assign r_kind = kind_q[gi+1];
        assign r_time = time_q[gi+1];
        assign r_dec  = dec_q[gi+1];
      end
      sceq_cell u_cell (
        .clk        (clk),
        .ctl        (ctl),
        .valid      (count_r > CNT_W'(gi)),
        .new_kind   (in_ch.event_kind),
        .new_time   (new_time),
        .frame_time (in_ch.frame_time),
        .first_kind (first_kind_r),
        .last_kind  (last_kind_r),
        .left_kind  (l_kind),
        .left_time  (l_time),
        .left_ins   (l_ins),
        .hit_in     (l_hit),
        .right_kind (r_kind),
        .right_time (r_time),
        .right_dec  (r_dec),
        .cell_kind  (kind_q[gi]),
        .cell_time  (time_q[gi]),
        .dec_time   (dec_q[gi]),
        .ins        (ins_q[gi]),
        .hit_out    (hit_q[gi])
      );
    end
  endgenerate

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    out_valid_nxt  = out_valid_r & ~out_ch.ready;
    fired_nxt      = fired_r;
    fired_kind_nxt = fired_kind_r;
    dropped_nxt    = dropped_r;
    if (in_fire) begin
      fired_nxt      = 1'b0;
      fired_kind_nxt = '0;
      dropped_nxt    = 1'b0;
      case (in_ch.func)
        FUNC_ADD: begin
          out_valid_nxt = 1'b1;
          if (full) begin
            dropped_nxt = 1'b1;
          end else begin
            count_nxt = count_r + CNT_W'(1);
          end
        end
        FUNC_TICK: begin
          out_valid_nxt = 1'b1;
          if (ctl.pop) begin
            fired_nxt      = 1'b1;
            fired_kind_nxt = kind_q[0];
            count_nxt      = count_r - CNT_W'(1);
          end
        end
        FUNC_CLR_RANGE: begin
          state_nxt = ST_CLR;
        end
        FUNC_CLR_ALL: begin
          out_valid_nxt = 1'b1;
          count_nxt     = '0;
        end
        default: begin
          out_valid_nxt = 1'b1;
        end
      endcase
    end else if (state_r == ST_CLR) begin
      if (any_hit) begin
        count_nxt = count_r - CNT_W'(1);
      end else if (out_free) begin
        out_valid_nxt  = 1'b1;
        fired_nxt      = 1'b0;
        fired_kind_nxt = '0;
        dropped_nxt    = 1'b0;
        state_nxt      = ST_IDLE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    fired_r      <= fired_nxt;
    fired_kind_r <= fired_kind_nxt;
    dropped_r    <= dropped_nxt;
  end

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_kind_r <= '0;
      last_kind_r  <= '0;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        REG_FIRST_KIND: first_kind_r <= cfg_ch.data;
        REG_LAST_KIND:  last_kind_r  <= cfg_ch.data;
        default: begin
        end
      endcase
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.fired      = fired_r;
  assign out_ch.fired_kind = fired_kind_r;
  assign out_ch.dropped    = dropped_r;
  assign out_ch.occupancy  = occ_t'(count_r);

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(QUEUE_DEPTH))
    else $error("queue count exceeds depth");

  a_full_drop: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && (in_ch.func == FUNC_ADD) && full |=> out_ch.valid && out_ch.dropped)
    else $error("add to a full queue was not reported as dropped");

  a_empty_tick: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && (in_ch.func == FUNC_TICK) && (count_r == '0) |=> !out_ch.fired)
    else $error("tick on an empty queue fired");

  a_clr_block: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CLR) |-> !in_ch.ready)
    else $error("input taken during clear-range");

  a_head_sorted: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r >= CNT_W'(2)) |-> (time_q[0] <= time_q[1]))
    else $error("head entries out of order");

endmodule
